/* sv/dhds_pkg.sv */
// ----------------------------------------------------------------------------
// dhds_pkg
// Shared types and constants for the drive-hold-drive sequencer.
// ----------------------------------------------------------------------------
package dhds_pkg;

    // field widths
    localparam int SPEED_W  = 10;
    localparam int TICKS_W  = 13;
    localparam int YAW_W    = 15;
    localparam int WHEEL_W  = 16;
    localparam int TURN_W   = 9;
    localparam int COUNT_W  = 16;
    localparam int SETTLE_W = 8;
    localparam int CFG_IDX_W = 2;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    // sequencing constants
    localparam int SETTLE_COUNT       = 6;
    localparam int HOLD_TIMEOUT_EXTRA = 120;
    localparam int STILL_SUM          = 30;
    localparam int SPEED_LIMIT        = 1000;
    localparam int TURN_LIMIT         = 250;
    localparam int YAW_HALF_TURN      = 11520;
    localparam int YAW_FULL_TURN      = 23040;

    // reset values of the configuration registers
    localparam logic [SPEED_W-1:0] CRUISE_SPEED_RST = SPEED_W'(600);
    localparam logic [TICKS_W-1:0] DRIVE_TICKS_RST  = TICKS_W'(600);
    localparam logic [TICKS_W-1:0] HOLD_TICKS_RST   = TICKS_W'(400);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DRIVE    = 2'd1,
        PH_HOLD     = 2'd2,
        PH_CONTINUE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_SPEED = 2'd0,
        CFG_DRIVE_TICKS  = 2'd1,
        CFG_HOLD_TICKS   = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

endpackage

/* sv/drive_hold_drive_sequencer_top.sv */
// ----------------------------------------------------------------------------
// drive_hold_drive_sequencer_top
// Event-driven drive / hold / drive sequencer with heading hold.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  s_        in         s_tvalid / s_tready        event: op in tuser, rest in tdata
//  m_        out        m_tvalid / m_tready        held command and phase
//  cfg_      in         cfg_valid / cfg_ready      register index and write data
//
//  every event transfer yields exactly one result transfer
//  one event per cycle while the result register is empty or being drained: the whole update
//  is one pass of logic into the state registers, which double as the result register
//  m_tvalid is registered and rises in the cycle after the event transfer
//  s_tready stays high while the result register is empty or being drained
//  aresetn (synchronous, active low) clears the state and loads config defaults
//  cfg_ready is always high; writes take effect from the next event
//
module drive_hold_drive_sequencer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // event input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] kill, [15:1] yaw, [31:16] left_wheel_speed, [47:32] right_wheel_speed
    input  logic [dhds_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] operation
    input  logic [dhds_pkg::S_TUSER_W-1:0]     s_tuser,
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] drive_active, [10:1] commanded_speed, [19:11] commanded_turn,
    // [21:20] phase, [23:22] zero
    output logic [dhds_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dhds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dhds_pkg::TICKS_W-1:0]       cfg_data
);
    import dhds_pkg::*;

    // configuration registers
    logic [SPEED_W-1:0] cruise_speed_reg;
    logic [TICKS_W-1:0] drive_ticks_reg;
    logic [TICKS_W-1:0] hold_ticks_reg;

    // sequencer state
    phase_t                     phase_reg,   phase_next;
    logic [COUNT_W-1:0]         count_reg,   count_next;
    logic signed [YAW_W-1:0]    target_reg,  target_next;
    logic [SETTLE_W-1:0]        settle_reg,  settle_next;
    logic                       active_reg,  active_next;
    logic [SPEED_W-1:0]         speed_reg,   speed_next;
    logic signed [TURN_W-1:0]   turn_reg,    turn_next;
    logic                       m_valid_reg;

    // unpacked event fields
    op_t                     op;
    logic                    kill;
    logic signed [YAW_W-1:0] yaw;
    logic signed [WHEEL_W-1:0] left_wheel;
    logic signed [WHEEL_W-1:0] right_wheel;

    logic                    s_xfer;
    logic                    cfg_xfer;

    // per-tick helpers
    logic [COUNT_W-1:0]      count_inc;
    logic [WHEEL_W:0]        left_abs;
    logic [WHEEL_W:0]        right_abs;
    logic [WHEEL_W+1:0]      wheel_sum;
    logic                    wheels_still;
    logic [SETTLE_W-1:0]     settle_upd;
    logic [TICKS_W:0]        hold_limit;
    logic [SPEED_W-1:0]      speed_sat;
    logic signed [TURN_W-1:0] tick_turn;

    assign op          = op_t'(s_tuser[1:0]);
    assign kill        = s_tdata[0];
    assign yaw         = s_tdata[15:1];
    assign left_wheel  = s_tdata[31:16];
    assign right_wheel = s_tdata[47:32];

    // result register drains in the same cycle a new event lands
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // heading-hold turn against the locked target
    dhds_heading u_heading (
        .yaw            (yaw),
        .heading_target (target_reg),
        .turn           (tick_turn)
    );

    // configuration writes; an index past the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cruise_speed_reg <= CRUISE_SPEED_RST;
            drive_ticks_reg  <= DRIVE_TICKS_RST;
            hold_ticks_reg   <= HOLD_TICKS_RST;
        end else if (cfg_xfer) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CRUISE_SPEED: cruise_speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_DRIVE_TICKS:  drive_ticks_reg  <= cfg_data;
                CFG_HOLD_TICKS:   hold_ticks_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // helper arithmetic for a tick
    always_comb begin
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

        if (left_wheel < 0) begin
            left_abs = -{left_wheel[WHEEL_W-1], left_wheel};
        end else begin
            left_abs = {1'b0, left_wheel};
        end
        if (right_wheel < 0) begin
            right_abs = -{right_wheel[WHEEL_W-1], right_wheel};
        end else begin
            right_abs = {1'b0, right_wheel};
        end
        wheel_sum    = {1'b0, left_abs} + {1'b0, right_abs};
        wheels_still = wheel_sum <= (WHEEL_W+2)'(STILL_SUM);

        if (!wheels_still) begin
            settle_upd = '0;
        end else if (settle_reg == '1) begin
            settle_upd = settle_reg;
        end else begin
            settle_upd = settle_reg + 1'b1;
        end

        hold_limit = {1'b0, hold_ticks_reg} + (TICKS_W+1)'(HOLD_TIMEOUT_EXTRA);

        speed_sat = (cruise_speed_reg > SPEED_W'(SPEED_LIMIT)) ? SPEED_W'(SPEED_LIMIT)
                                                               : cruise_speed_reg;
    end

    // next-state logic for one event
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        target_next = target_reg;
        settle_next = settle_reg;
        active_next = active_reg;
        speed_next  = speed_reg;
        turn_next   = turn_reg;

        unique case (op)
            OP_TICK: begin
                // killed or idle ticks freeze everything
                if (!kill && phase_reg != PH_IDLE) begin
                    count_next = count_inc;
                    if (phase_reg == PH_DRIVE &&
                        (drive_ticks_reg == '0 ||
                         count_inc >= COUNT_W'(drive_ticks_reg))) begin
                        phase_next  = PH_HOLD;
                        count_next  = '0;
                        settle_next = '0;
                    end else if (phase_reg == PH_HOLD && hold_ticks_reg == '0) begin
                        // zero hold length goes straight on
                        phase_next = PH_CONTINUE;
                        count_next = '0;
                    end else if (phase_reg == PH_HOLD) begin
                        settle_next = settle_upd;
                        if (count_inc >= COUNT_W'(hold_ticks_reg) &&
                            (settle_upd >= SETTLE_W'(SETTLE_COUNT) ||
                             count_inc >= COUNT_W'(hold_limit))) begin
                            phase_next = PH_CONTINUE;
                            count_next = '0;
                        end
                    end

                    active_next = 1'b1;
                    if (phase_next == PH_DRIVE || phase_next == PH_CONTINUE) begin
                        speed_next = speed_sat;
                        turn_next  = tick_turn;
                    end else begin
                        speed_next = '0;
                        turn_next  = '0;
                    end
                end
            end
            OP_START: begin
                // error is zero on the locked heading
                phase_next  = PH_DRIVE;
                count_next  = '0;
                target_next = yaw;
                settle_next = '0;
                active_next = 1'b1;
                speed_next  = speed_sat;
                turn_next   = '0;
            end
            OP_STOP: begin
                // heading target is kept
                phase_next  = PH_IDLE;
                count_next  = '0;
                settle_next = '0;
                active_next = 1'b0;
                speed_next  = '0;
                turn_next   = '0;
            end
            OP_RESTART: begin
                // held command and settle count stay as they are
                phase_next  = PH_DRIVE;
                count_next  = '0;
                target_next = yaw;
            end
            default: begin
            end
        endcase
    end

    // state registers, which also form the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= '0;
            target_reg  <= '0;
            settle_reg  <= '0;
            active_reg  <= 1'b0;
            speed_reg   <= '0;
            turn_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                target_reg <= target_next;
                settle_reg <= settle_next;
                active_reg <= active_next;
                speed_reg  <= speed_next;
                turn_reg   <= turn_next;
            end
            if (s_xfer) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, phase_reg, turn_reg, speed_reg, active_reg};

endmodule

/* sv/dhds_heading.sv */
// ----------------------------------------------------------------------------
// dhds_heading
// Heading-hold turn: wrapped yaw error times -17/128, truncated, clamped.
// ----------------------------------------------------------------------------
module dhds_heading (
    input  logic signed [dhds_pkg::YAW_W-1:0]  yaw,
    input  logic signed [dhds_pkg::YAW_W-1:0]  heading_target,
    output logic signed [dhds_pkg::TURN_W-1:0] turn
);
    import dhds_pkg::*;

    logic signed [YAW_W+1:0] err_raw;
    logic signed [YAW_W+1:0] err_wrap;
    logic        [YAW_W-2:0] err_mag;
    logic        [YAW_W+2:0] prod;
    logic        [YAW_W-5:0] quot;
    logic        [TURN_W-2:0] mag_clamped;

    // one wrap step is enough for any pair of 15 bit angles
    always_comb begin
        err_raw = {{2{yaw[YAW_W-1]}}, yaw} - {{2{heading_target[YAW_W-1]}}, heading_target};
        if (err_raw > YAW_HALF_TURN) begin
            err_wrap = err_raw - (YAW_W+2)'(YAW_FULL_TURN);
        end else if (err_raw <= -YAW_HALF_TURN) begin
            err_wrap = err_raw + (YAW_W+2)'(YAW_FULL_TURN);
        end else begin
            err_wrap = err_raw;
        end
    end

    // work on the magnitude so the shift truncates toward zero
    always_comb begin
        if (err_wrap < 0) begin
            err_mag = (YAW_W-1)'(-err_wrap);
        end else begin
            err_mag = (YAW_W-1)'(err_wrap);
        end
        prod = ({4'b0, err_mag} << 4) + {4'b0, err_mag};
        quot = prod[YAW_W+2:7];
        if (quot > (YAW_W-4)'(TURN_LIMIT)) begin
            mag_clamped = (TURN_W-1)'(TURN_LIMIT);
        end else begin
            mag_clamped = quot[TURN_W-2:0];
        end
        // turn opposes the error
        if (err_wrap < 0) begin
            turn = signed'({1'b0, mag_clamped});
        end else begin
            turn = -signed'({1'b0, mag_clamped});
        end
    end

endmodule

/* dv/dhds_command_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhds_command_checker
// Watches the event, result and register channels of the sequencer, keeps
// its own copy of the phase state, predicts the command for every event
// and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module dhds_command_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [dhds_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [dhds_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [dhds_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dhds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dhds_pkg::TICKS_W-1:0]       cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);

    import dhds_pkg::*;

    typedef struct packed {
        logic               active;
        logic [SPEED_W-1:0] speed;
        logic [TURN_W-1:0]  turn;
        phase_t             phase;
    } drive_command_t;

    // register copies
    logic [SPEED_W-1:0]        cruise_speed;
    logic [TICKS_W-1:0]        drive_len;
    logic [TICKS_W-1:0]        hold_len;

    // sequencer state
    phase_t                    seq_phase;
    logic [COUNT_W-1:0]        tick_count;
    logic signed [YAW_W-1:0]   heading_target;
    logic [SETTLE_W-1:0]       settle_count;
    logic                      cmd_active;
    logic [SPEED_W-1:0]        cmd_speed;
    logic [TURN_W-1:0]         cmd_turn;

    drive_command_t            expected_commands[$];
    int                        results_seen;

    initial begin
        mismatches   = 0;
        results_seen = 0;
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 50)
            $display("[%0t] result %0d %s: expected %0d, got %0d",
                     $time, results_seen, what, want, got);
    endtask

    function automatic logic [SPEED_W-1:0] limited_speed();
        return (cruise_speed > SPEED_LIMIT) ? SPEED_W'(SPEED_LIMIT) : cruise_speed;
    endfunction

    // -8.5 per degree of wrapped error, truncated toward zero, then clamped
    function automatic logic [TURN_W-1:0] heading_hold_turn(input logic signed [YAW_W-1:0] yaw);
        int err;
        int turn;
        err = int'(yaw) - int'(heading_target);
        while (err > YAW_HALF_TURN)
            err -= YAW_FULL_TURN;
        while (err <= -YAW_HALF_TURN)
            err += YAW_FULL_TURN;
        turn = (-17 * err) / 128;
        if (turn > TURN_LIMIT)
            turn = TURN_LIMIT;
        if (turn < -TURN_LIMIT)
            turn = -TURN_LIMIT;
        return TURN_W'(turn);
    endfunction

    task automatic advance_tick(input logic signed [YAW_W-1:0] yaw,
                                input logic signed [WHEEL_W-1:0] left,
                                input logic signed [WHEEL_W-1:0] right);
        int lmag;
        int rmag;
        if (tick_count != '1)
            tick_count++;
        if (seq_phase == PH_DRIVE && (drive_len == 0 || tick_count >= drive_len)) begin
            seq_phase    = PH_HOLD;
            tick_count   = '0;
            settle_count = '0;
        end else if (seq_phase == PH_HOLD && hold_len == 0) begin
            seq_phase  = PH_CONTINUE;
            tick_count = '0;
        end else if (seq_phase == PH_HOLD) begin
            lmag = int'(left);
            rmag = int'(right);
            if (lmag < 0)
                lmag = -lmag;
            if (rmag < 0)
                rmag = -rmag;
            if (lmag + rmag <= STILL_SUM) begin
                if (settle_count != '1)
                    settle_count++;
            end else begin
                settle_count = '0;
            end
            if (tick_count >= hold_len &&
                (settle_count >= SETTLE_COUNT ||
                 int'(tick_count) >= int'(hold_len) + HOLD_TIMEOUT_EXTRA)) begin
                seq_phase  = PH_CONTINUE;
                tick_count = '0;
            end
        end
        cmd_active = 1'b1;
        if (seq_phase == PH_DRIVE || seq_phase == PH_CONTINUE) begin
            cmd_speed = limited_speed();
            cmd_turn  = heading_hold_turn(yaw);
        end else begin
            cmd_speed = '0;
            cmd_turn  = '0;
        end
    endtask

    task automatic apply_event(input op_t op, input logic kill,
                               input logic signed [YAW_W-1:0] yaw,
                               input logic signed [WHEEL_W-1:0] left,
                               input logic signed [WHEEL_W-1:0] right);
        drive_command_t cmd;
        case (op)
            OP_TICK: begin
                if (!kill && seq_phase != PH_IDLE)
                    advance_tick(yaw, left, right);
            end
            OP_START: begin
                seq_phase      = PH_DRIVE;
                tick_count     = '0;
                heading_target = yaw;
                settle_count   = '0;
                cmd_active     = 1'b1;
                cmd_speed      = limited_speed();
                cmd_turn       = heading_hold_turn(yaw);
            end
            OP_STOP: begin
                seq_phase    = PH_IDLE;
                tick_count   = '0;
                settle_count = '0;
                cmd_active   = 1'b0;
                cmd_speed    = '0;
                cmd_turn     = '0;
            end
            OP_RESTART: begin
                seq_phase      = PH_DRIVE;
                tick_count     = '0;
                heading_target = yaw;
            end
            default: ;
        endcase
        cmd.active = cmd_active;
        cmd.speed  = cmd_speed;
        cmd.turn   = cmd_turn;
        cmd.phase  = seq_phase;
        expected_commands.push_back(cmd);
    endtask

    task automatic write_setting(input cfg_idx_t idx, input logic [TICKS_W-1:0] data);
        case (idx)
            CFG_CRUISE_SPEED: cruise_speed = data[SPEED_W-1:0];
            CFG_DRIVE_TICKS:  drive_len    = data;
            CFG_HOLD_TICKS:   hold_len     = data;
            default: ;
        endcase
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        drive_command_t want;
        results_seen++;
        if (expected_commands.size() == 0) begin
            report_mismatch("result with nothing expected", 0, int'(data));
        end else begin
            want = expected_commands.pop_front();
            if (data[0] !== want.active)
                report_mismatch("drive_active", want.active, data[0]);
            if (data[10:1] !== want.speed)
                report_mismatch("commanded_speed", want.speed, data[10:1]);
            if (data[19:11] !== want.turn)
                report_mismatch("commanded_turn", $signed(want.turn), $signed(data[19:11]));
            if (data[21:20] !== want.phase)
                report_mismatch("phase", want.phase, data[21:20]);
        end
    endtask

    // results are checked before the new event is predicted: a result is held in
    // the result register, so it never belongs to the event taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cruise_speed   = CRUISE_SPEED_RST;
            drive_len      = DRIVE_TICKS_RST;
            hold_len       = HOLD_TICKS_RST;
            seq_phase      = PH_IDLE;
            tick_count     = '0;
            heading_target = '0;
            settle_count   = '0;
            cmd_active     = 1'b0;
            cmd_speed      = '0;
            cmd_turn       = '0;
            expected_commands.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                apply_event(op_t'(s_tuser), s_tdata[0], s_tdata[15:1],
                            s_tdata[31:16], s_tdata[47:32]);
            if (cfg_valid && cfg_ready)
                write_setting(cfg_idx_t'(cfg_index), cfg_data);
            outstanding <= expected_commands.size();
        end
    end

endmodule

/* dv/tb_drive_hold_drive_sequencer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_hold_drive_sequencer_top
// Drives the sequencer with a short hand-picked event list, then with
// start / tick / stop missions under a series of register settings, while
// both stream sides idle at random. The checker beside the block predicts
// and compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_drive_hold_drive_sequencer_top;

    import dhds_pkg::*;

    // stimulus stops once this many events have gone in
    localparam int EVENT_TARGET  = 2000;
    // events per register setting before moving on
    localparam int SETTING_SPAN  = 150;
    // longest mission in ticks, keeps the long-phase settings cheap
    localparam int MISSION_CAP   = 400;

    typedef enum int {
        WHEELS_STILL,
        WHEELS_NOISY,
        WHEELS_MIXED
    } wheel_mode_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    // [0] kill, [15:1] yaw, [31:16] left_wheel_speed, [47:32] right_wheel_speed
    logic [S_TDATA_W-1:0]       s_tdata   = '0;
    // [1:0] operation
    logic [S_TUSER_W-1:0]       s_tuser   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    // [0] drive_active, [10:1] commanded_speed, [19:11] commanded_turn, [21:20] phase
    logic [M_TDATA_W-1:0]       m_tdata;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [TICKS_W-1:0]         cfg_data  = '0;

    int                         mismatches;
    int                         outstanding;
    int                         events_sent   = 0;
    // when set the event side sends back to back
    bit                         sender_steady = 1'b0;

    drive_hold_drive_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dhds_command_checker u_command_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (sender_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // fold a yaw back into the half-turn range
    function automatic int wrap_yaw(input int y);
        if (y > YAW_HALF_TURN)
            y -= YAW_FULL_TURN;
        else if (y < -YAW_HALF_TURN)
            y += YAW_FULL_TURN;
        return y;
    endfunction

    function automatic int random_yaw();
        return int'($urandom_range(0, 2 * YAW_HALF_TURN)) - YAW_HALF_TURN;
    endfunction

    // still wheels keep |left| + |right| within the settle limit, with the
    // limit itself hit often; mixed mode adds near misses and full noise
    task automatic pick_wheels(input wheel_mode_t mode,
                               output logic [WHEEL_W-1:0] left,
                               output logic [WHEEL_W-1:0] right);
        int r;
        int total;
        int lmag;
        r = $urandom_range(0, 99);
        if (mode == WHEELS_NOISY || (mode == WHEELS_MIXED && r >= 90)) begin
            left  = WHEEL_W'($urandom());
            right = WHEEL_W'($urandom());
        end else begin
            if (mode == WHEELS_MIXED && r >= 80)
                total = $urandom_range(STILL_SUM + 1, STILL_SUM + 10);
            else if (r < 20)
                total = STILL_SUM;
            else
                total = $urandom_range(0, STILL_SUM);
            lmag  = $urandom_range(0, total);
            left  = WHEEL_W'(lmag);
            right = WHEEL_W'(total - lmag);
            if ($urandom_range(0, 1))
                left = -left;
            if ($urandom_range(0, 1))
                right = -right;
        end
    endtask

    // one event transfer; valid stays high into the next event unless a gap
    // is drawn, so it is never dropped and raised within the same step
    task automatic send_event(input op_t op, input logic kill, input int yaw,
                              input logic [WHEEL_W-1:0] left,
                              input logic [WHEEL_W-1:0] right);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {right, left, 15'(yaw), kill};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        events_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop sending and wait until every predicted result has been taken;
    // the first edge lets the checker count an event accepted just now
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= TICKS_W'(value);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // registers only change with the block idle
    task automatic load_settings(input int cruise, input int drive, input int hold,
                                 input bit poke_unused);
        wait_idle();
        write_reg(CFG_CRUISE_SPEED, cruise);
        write_reg(CFG_DRIVE_TICKS, drive);
        write_reg(CFG_HOLD_TICKS, hold);
        // the spare index must leave every register alone
        if (poke_unused)
            write_reg(CFG_UNUSED, $urandom_range(0, (1 << TICKS_W) - 1));
        cfg_valid <= 1'b0;
    endtask

    // start, a run of ticks with the yaw wandering around the locked heading,
    // then usually a stop; a clean mission carries no stray start, restart
    // or stop so that the hold can run its full course
    task automatic run_mission(input int n_ticks, input wheel_mode_t mode, input bit clean);
        int base;
        int y;
        int i;
        int r;
        op_t op;
        logic kill;
        logic [WHEEL_W-1:0] lw;
        logic [WHEEL_W-1:0] rw;
        base = random_yaw();
        pick_wheels(mode, lw, rw);
        send_event(OP_START, $urandom_range(0, 9) == 0, base, lw, rw);
        for (i = 0; i < n_ticks; i++) begin
            r  = $urandom_range(0, 99);
            op = OP_TICK;
            if (!clean) begin
                if (r < 3)
                    op = OP_RESTART;
                else if (r < 5)
                    op = OP_START;
                else if (r < 7)
                    op = OP_STOP;
            end
            kill = ($urandom_range(0, 24) == 0);
            // mostly within the unclamped turn band, sometimes anywhere
            if ($urandom_range(0, 99) < 85)
                y = wrap_yaw(base + int'($urandom_range(0, 4000)) - 2000);
            else
                y = random_yaw();
            if (op == OP_START || op == OP_RESTART)
                base = y;
            pick_wheels(mode, lw, rw);
            send_event(op, kill, y, lw, rw);
        end
        if ($urandom_range(0, 9) < 7) begin
            pick_wheels(WHEELS_NOISY, lw, rw);
            send_event(OP_STOP, $urandom_range(0, 1), random_yaw(), lw, rw);
        end
    endtask

    // stray events of any kind between missions
    task automatic send_noise(input int n);
        int i;
        logic [WHEEL_W-1:0] lw;
        logic [WHEEL_W-1:0] rw;
        for (i = 0; i < n; i++) begin
            pick_wheels(WHEELS_NOISY, lw, rw);
            send_event(op_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                       random_yaw(), lw, rw);
        end
    endtask

    // one register setting and a batch of missions under it; the first
    // mission is clean with still wheels so settling can be reached
    task automatic run_setting(input int cruise, input int drive, input int hold,
                               input bit poke_unused);
        int first_event;
        int len;
        bit first;
        load_settings(cruise, drive, hold, poke_unused);
        first_event = events_sent;
        first       = 1'b1;
        while (events_sent < first_event + SETTING_SPAN) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            len = drive + hold + $urandom_range(0, HOLD_TIMEOUT_EXTRA + 20);
            if (len > MISSION_CAP)
                len = MISSION_CAP;
            if (first)
                run_mission(len, WHEELS_STILL, 1'b1);
            else
                run_mission(len, wheel_mode_t'($urandom_range(0, 2)), $urandom_range(0, 1));
            send_noise($urandom_range(0, 4));
            first = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready stalls of random length, with long ready stretches
    // ------------------------------------------------------------------
    initial begin
        int r;
        int stall;
        int ready_run;
        repeat (6) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 50)
                stall = 0;
            else if (r < 90)
                stall = $urandom_range(1, 3);
            else
                stall = $urandom_range(5, 40);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 8);
            repeat (ready_run) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // event side and verdict
    // ------------------------------------------------------------------
    initial begin
        int cruise;
        int drive;
        int hold;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // hand-picked events under the reset settings (600 / 600 / 400)
        // tick and stop while idle change nothing
        send_event(OP_TICK,    1'b0,      0, 16'h0000, 16'h0000);
        send_event(OP_STOP,    1'b0,      0, 16'h0000, 16'h0000);
        // restart from idle enters first drive but keeps the inactive command
        send_event(OP_RESTART, 1'b0, -11520, 16'h0000, 16'h0000);
        // first tick after that: error of a full turn wraps to zero
        send_event(OP_TICK,    1'b0,  11520, 16'h0000, 16'h0000);
        // small error inside the unclamped band
        send_event(OP_TICK,    1'b0, -11392, 16'h0010, 16'hFFF0);
        // killed tick freezes everything
        send_event(OP_TICK,    1'b1,   5000, 16'h7FFF, 16'h8000);
        // start ignores kill and relocks at the upper yaw extreme
        send_event(OP_START,   1'b1,  11520, 16'h0000, 16'h0000);
        // minus a full turn wraps back to zero error
        send_event(OP_TICK,    1'b0, -11520, 16'h0000, 16'h0000);
        // half-turn error on the closed side of the wrap, clamped
        send_event(OP_TICK,    1'b0,      0, 16'h0000, 16'h0000);
        send_event(OP_TICK,    1'b0,  10520, 16'h0000, 16'h0000);
        // wheel extremes, error just past a half turn
        send_event(OP_TICK,    1'b0,     -1, 16'h8000, 16'h7FFF);
        send_event(OP_START,   1'b0,      0, 16'h7FFF, 16'h8000);
        send_event(OP_TICK,    1'b0,  11520, 16'h0000, 16'h0000);
        send_event(OP_TICK,    1'b0, -11520, 16'h0000, 16'h0000);
        // truncation toward zero right at the clamp edge, both signs
        send_event(OP_TICK,    1'b0,   1882, 16'h0000, 16'h0000);
        send_event(OP_TICK,    1'b0,  -1883, 16'h0000, 16'h0000);
        // restart while driving keeps the held command
        send_event(OP_RESTART, 1'b0,    100, 16'h0000, 16'h0000);
        send_event(OP_STOP,    1'b1,   -100, 16'h0000, 16'h0000);
        send_event(OP_TICK,    1'b0,    200, 16'h0000, 16'h0000);
        send_event(OP_TICK,    1'b1,    300, 16'h0000, 16'h0000);

        // fixed settings: speed extremes and the saturated write, skipped
        // phases, zero hold, long phases, and a hold long enough for the
        // settle count to saturate
        run_setting(1000,    5,   10, 1'b1);
        run_setting(   0,    0,    0, 1'b0);
        run_setting(1023,    0,    3, 1'b0);
        run_setting( 350,    3,    0, 1'b0);
        run_setting(   1, 6000, 6000, 1'b0);
        run_setting( 777,    2,  300, 1'b0);
        run_setting( 600,    1,    0, 1'b0);
        run_setting( 512,    8,   20, 1'b0);

        // random settings, mostly short phases
        while (events_sent < EVENT_TARGET) begin
            cruise = $urandom_range(0, SPEED_LIMIT);
            drive  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 6000)
                                                 : $urandom_range(0, 12);
            hold   = ($urandom_range(0, 4) == 0) ? $urandom_range(26, 200)
                                                 : $urandom_range(0, 25);
            run_setting(cruise, drive, hold, 1'b0);
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
sv/dhds_pkg.sv
sv/dhds_heading.sv
sv/drive_hold_drive_sequencer_top.sv
dv/dhds_command_checker.sv
dv/tb_drive_hold_drive_sequencer_top.sv
